// ===== sv/cubic_hermite_eval_defines.svh =====
// Assertion macros for the cubic Hermite evaluator checker.
// No dependencies; included by files that assert.
`ifndef CUBIC_HERMITE_EVAL_DEFINES_SVH
`define CUBIC_HERMITE_EVAL_DEFINES_SVH

// clocked check, masked while reset is asserted
`define CHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define CHE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/che_pkg.sv =====
// Shared constants and types for the cubic Hermite evaluator.
// No dependencies.
`timescale 1ns / 1ps

package che_pkg;

  // fixed-point format of all ports
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // partial product limb width of the multipliers
  localparam int LIMB_W = 32;

  // exact numerator width ahead of the divider
  localparam int NUM_W  = 168;

  // quotient bits: 32 result bits plus one overflow bit
  localparam int QUO_W  = DATA_W + 1;
  localparam int REM_W  = NUM_W + QUO_W + 1;

  // stages before the divider, divider latency, whole pipe
  localparam int PRE_DEPTH  = 13;
  localparam int DIV_LAT    = QUO_W + 3;
  localparam int PIPE_DEPTH = PRE_DEPTH + DIV_LAT + 1;

  // saturation limits
  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // one division in flight, handed from cell to cell
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dsr;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } div_lane_t;

endpackage

// ===== sv/che_mul.sv =====
// Two-stage signed multiplier: operand A cut into 32-bit limbs, then summed.
// Depends on che_pkg.
`timescale 1ns / 1ps

module che_mul #(
  parameter int A_W = 33,
  parameter int B_W = 33
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [A_W-1:0]  a,
  input  logic signed [B_W-1:0]  b,
  output logic signed [A_W+B_W-1:0] p
);

  localparam int LW    = che_pkg::LIMB_W;
  localparam int NL    = (A_W + LW - 1) / LW;
  localparam int EXT_W = NL * LW;
  localparam int PP_W  = LW + 1 + B_W;
  localparam int P_W   = A_W + B_W;

  logic signed [EXT_W-1:0] a_ext;
  logic signed [PP_W-1:0]  pp_r [NL];
  logic signed [P_W-1:0]   acc;
  logic signed [P_W-1:0]   p_r;

  assign a_ext = EXT_W'(a);

  // limb products; lower limbs unsigned, top limb carries the sign
  for (genvar i = 0; i < NL; i++) begin : g_limb
    if (i == NL - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (en) begin
          pp_r[i] <= PP_W'($signed(a_ext[i*LW +: LW])) * PP_W'(b);
        end
      end
    end else begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          pp_r[i] <= PP_W'($signed({1'b0, a_ext[i*LW +: LW]})) * PP_W'(b);
        end
      end
    end
  end

  // weighted sum of the limb products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NL; i++) begin
      acc = acc + (P_W'(pp_r[i]) <<< (i * LW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc;
    end
  end

  assign p = p_r;

endmodule

// ===== sv/che_div_cell.sv =====
// One restoring-division cell: one quotient bit, divisor shifts for the next cell.
// Depends on che_pkg.
`timescale 1ns / 1ps

module che_div_cell (
  input  logic               clk,
  input  logic               en,
  input  che_pkg::div_lane_t lane_i,
  output che_pkg::div_lane_t lane_o
);

  che_pkg::div_lane_t lane_nxt;
  che_pkg::div_lane_t lane_r;
  logic               ge;

  // trial subtract
  always_comb begin
    ge           = (lane_i.rem >= lane_i.dsr);
    lane_nxt.rem = ge ? (lane_i.rem - lane_i.dsr) : lane_i.rem;
    lane_nxt.dsr = lane_i.dsr >> 1;
    lane_nxt.quo = {lane_i.quo[che_pkg::QUO_W-2:0], ge};
    lane_nxt.neg = lane_i.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ===== sv/che_div.sv =====
// Pipelined rounding divider: sign split, rounding offset, chain of cells, saturate.
// Depends on che_pkg and che_div_cell.
`timescale 1ns / 1ps

module che_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [che_pkg::NUM_W-1:0] num,
  input  logic signed [che_pkg::NUM_W-1:0] den,
  output logic        [che_pkg::DATA_W-1:0] res,
  output logic                             sat
);

  localparam int NW = che_pkg::NUM_W;
  localparam int RW = che_pkg::REM_W;
  localparam int QW = che_pkg::QUO_W;
  localparam int DW = che_pkg::DATA_W;

  logic [NW-1:0]      an_r;
  logic [NW-1:0]      dn_r;
  logic               neg_r;
  che_pkg::div_lane_t lane0_r;
  che_pkg::div_lane_t lane [QW+1];
  logic [QW-1:0]      quo;
  logic [DW-1:0]      lim;
  logic               over;
  logic [DW-1:0]      res_r;
  logic               sat_r;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      an_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      dn_r  <= den[NW-1] ? NW'(-den) : NW'(den);
      neg_r <= num[NW-1] ^ den[NW-1];
    end
  end

  // round to nearest: divide 2|n|+|d| by 2|d|
  always_ff @(posedge clk) begin
    if (en) begin
      lane0_r.rem <= (RW'(an_r) << 1) + RW'(dn_r);
      lane0_r.dsr <= RW'(dn_r) << QW;
      lane0_r.quo <= '0;
      lane0_r.neg <= neg_r;
    end
  end

  assign lane[0] = lane0_r;

  // one quotient bit per cell, top bit flags overflow
  for (genvar g = 0; g < QW; g++) begin : g_cell
    che_div_cell u_cell (
      .clk    (clk),
      .en     (en),
      .lane_i (lane[g]),
      .lane_o (lane[g+1])
    );
  end

  // saturate and apply sign
  always_comb begin
    quo  = lane[QW].quo;
    lim  = lane[QW].neg ? che_pkg::SAT_NEG : che_pkg::SAT_POS;
    over = quo[QW-1] | (quo[DW-1:0] > lim);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= over ? lim : (lane[QW].neg ? (DW'(0) - quo[DW-1:0]) : quo[DW-1:0]);
      sat_r <= over;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// ===== sv/cubic_hermite_eval.sv =====
// Top level of the cubic Hermite evaluator: exact polynomial terms, two dividers.
// Depends on che_pkg, che_mul and che_div.
//
//   channel | ports                                     | dir
//   in      | in_valid, in_ready, in_query_x .. slope   | beat in
//   out     | out_valid, out_ready, out_interp_value,   | beat out
//           | out_interp_deriv, out_fault               |
//
// One beat per cycle sustained while out_ready holds; the pipe runs through four multiply levels
// and the 33-cell quotient chain of each divider.
// Reset (rst_n, synchronous) clears only the valid line; payload is not reset.
// A stalled output beat freezes the whole pipeline; in_ready drops with it.
`timescale 1ns / 1ps

module cubic_hermite_eval (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [che_pkg::DATA_W-1:0] in_query_x,
  input  logic signed [che_pkg::DATA_W-1:0] in_left_x,
  input  logic signed [che_pkg::DATA_W-1:0] in_left_value,
  input  logic signed [che_pkg::DATA_W-1:0] in_left_slope,
  input  logic signed [che_pkg::DATA_W-1:0] in_right_x,
  input  logic signed [che_pkg::DATA_W-1:0] in_right_value,
  input  logic signed [che_pkg::DATA_W-1:0] in_right_slope,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [che_pkg::DATA_W-1:0] out_interp_value,
  output logic signed [che_pkg::DATA_W-1:0] out_interp_deriv,
  output logic                             out_fault
);

  localparam int DW    = che_pkg::DATA_W;
  localparam int FW    = che_pkg::FRAC_W;
  localparam int NW    = che_pkg::NUM_W;
  localparam int DEPTH = che_pkg::PIPE_DEPTH;
  localparam int ZDEP  = DEPTH - 2;
  localparam int D_W   = DW + 1;
  localparam int A3_W  = DW + 4;
  localparam int SQ_W  = 2 * D_W;
  localparam int W_W   = SQ_W + 2;
  localparam int C3_W  = SQ_W + D_W;
  localparam int G_W   = SQ_W + D_W;
  localparam int A0_W  = W_W + DW;
  localparam int B0_W  = SQ_W + DW;
  localparam int S_W   = B0_W + 1;
  localparam int Q_W   = A0_W + 1;
  localparam int M6_W  = G_W + 3;
  localparam int P1_W  = C3_W + DW;
  localparam int P2_W  = G_W + A3_W;
  localparam int T_W   = S_W + D_W;
  localparam int QD_W  = Q_W + D_W;
  localparam int P3_W  = T_W + D_W;

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [ZDEP-1:0]  zero_r;

  // input registers
  logic signed [DW-1:0] qx_r, lx_r, lv_r, ls_r, rx_r, rv_r, rs_r;

  // stage 1
  logic signed [D_W-1:0]  u_nxt, v_nxt, d_nxt, dy_nxt;
  logic signed [A3_W-1:0] a_nxt;
  logic                   zero_nxt;
  logic signed [D_W-1:0]  u_s1_r, v_s1_r, d_s1_r, dy_s1_r;
  logic signed [A3_W-1:0] a_s1_r;
  logic signed [DW-1:0]   y0_s1_r, y0p_s1_r, y1p_s1_r;

  // stages 2..3 side data
  logic signed [D_W-1:0]  d_s2_r, v_s2_r, dy_s2_r, d_s3_r, v_s3_r, dy_s3_r;
  logic signed [A3_W-1:0] a_s2_r, a_s3_r;
  logic signed [DW-1:0]   y0_s2_r, y0p_s2_r, y1p_s2_r, y0_s3_r, y0p_s3_r, y1p_s3_r;
  logic signed [SQ_W-1:0] uu_s3, uv_s3, vv_s3, dd_s3;

  // stage 4
  logic signed [W_W-1:0]  w0_s4_r, w1_s4_r;
  logic signed [SQ_W-1:0] uu_s4_r, uv_s4_r, dd_s4_r;
  logic signed [D_W-1:0]  d_s4_r, v_s4_r, dy_s4_r;
  logic signed [A3_W-1:0] a_s4_r;
  logic signed [DW-1:0]   y0_s4_r, y0p_s4_r, y1p_s4_r;

  // stages 5..6
  logic signed [D_W-1:0]  d_s5_r, v_s5_r, d_s6_r, v_s6_r;
  logic signed [A3_W-1:0] a_s5_r, a_s6_r;
  logic signed [DW-1:0]   y0_s5_r, y0_s6_r;
  logic signed [C3_W-1:0] c3_s6;
  logic signed [G_W-1:0]  g_s6, m_s6;
  logic signed [A0_W-1:0] a0_s6, a1_s6;
  logic signed [B0_W-1:0] b0_s6, b1_s6;

  // stage 7
  logic signed [S_W-1:0]  s_s7_r;
  logic signed [Q_W-1:0]  q_s7_r;
  logic signed [M6_W-1:0] m6_s7_r, m6_s8_r, m6_s9_r, m6_s10_r, m6_s11_r;
  logic signed [C3_W-1:0] c3_s7_r, c3_s8_r, c3_s9_r, c3_s10_r, c3_s11_r;
  logic signed [G_W-1:0]  g_s7_r;
  logic signed [D_W-1:0]  d_s7_r, v_s7_r, v_s8_r, v_s9_r;
  logic signed [A3_W-1:0] a_s7_r;
  logic signed [DW-1:0]   y0_s7_r;

  // stages 9..11
  logic signed [P1_W-1:0] p1_s9, p1_s10_r, p1_s11_r;
  logic signed [P2_W-1:0] p2_s9, p2_s10_r, p2_s11_r;
  logic signed [T_W-1:0]  t_s9;
  logic signed [QD_W-1:0] qd_s9, qd_s10_r, qd_s11_r;
  logic signed [P3_W-1:0] p3_s11;

  // stage 12
  logic signed [NW-1:0] nv_r, nd_r, denv_r, dend_r;

  // divider results and output beat
  logic [DW-1:0] res_v, res_d;
  logic          sat_v, sat_d;
  logic [DW-1:0] out_value_r, out_deriv_r;
  logic          out_fault_r;

  // pipeline advances unless a finished beat is held
  assign en        = !vld_r[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // capture beat
  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= in_query_x;
      lx_r <= in_left_x;
      lv_r <= in_left_value;
      ls_r <= in_left_slope;
      rx_r <= in_right_x;
      rv_r <= in_right_value;
      rs_r <= in_right_slope;
    end
  end

  // offsets from the end points, 3d - 2u
  always_comb begin
    u_nxt    = D_W'(qx_r) - D_W'(lx_r);
    v_nxt    = D_W'(qx_r) - D_W'(rx_r);
    d_nxt    = D_W'(rx_r) - D_W'(lx_r);
    dy_nxt   = D_W'(rv_r) - D_W'(lv_r);
    a_nxt    = (A3_W'(d_nxt) <<< 1) + A3_W'(d_nxt) - (A3_W'(u_nxt) <<< 1);
    zero_nxt = (lx_r == rx_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_s1_r   <= u_nxt;
      v_s1_r   <= v_nxt;
      d_s1_r   <= d_nxt;
      dy_s1_r  <= dy_nxt;
      a_s1_r   <= a_nxt;
      y0_s1_r  <= lv_r;
      y0p_s1_r <= ls_r;
      y1p_s1_r <= rs_r;
      zero_r   <= {zero_r[ZDEP-2:0], zero_nxt};
    end
  end

  // squares and cross products
  che_mul #(.A_W(D_W), .B_W(D_W)) u_mul_uu (.clk(clk), .en(en), .a(u_s1_r), .b(u_s1_r), .p(uu_s3));
  che_mul #(.A_W(D_W), .B_W(D_W)) u_mul_uv (.clk(clk), .en(en), .a(u_s1_r), .b(v_s1_r), .p(uv_s3));
  che_mul #(.A_W(D_W), .B_W(D_W)) u_mul_vv (.clk(clk), .en(en), .a(v_s1_r), .b(v_s1_r), .p(vv_s3));
  che_mul #(.A_W(D_W), .B_W(D_W)) u_mul_dd (.clk(clk), .en(en), .a(d_s1_r), .b(d_s1_r), .p(dd_s3));

  always_ff @(posedge clk) begin
    if (en) begin
      d_s2_r   <= d_s1_r;
      v_s2_r   <= v_s1_r;
      dy_s2_r  <= dy_s1_r;
      a_s2_r   <= a_s1_r;
      y0_s2_r  <= y0_s1_r;
      y0p_s2_r <= y0p_s1_r;
      y1p_s2_r <= y1p_s1_r;
      d_s3_r   <= d_s2_r;
      v_s3_r   <= v_s2_r;
      dy_s3_r  <= dy_s2_r;
      a_s3_r   <= a_s2_r;
      y0_s3_r  <= y0_s2_r;
      y0p_s3_r <= y0p_s2_r;
      y1p_s3_r <= y1p_s2_r;
    end
  end

  // slope weights v^2 + 2uv and u^2 + 2uv
  always_ff @(posedge clk) begin
    if (en) begin
      w0_s4_r  <= W_W'(vv_s3) + (W_W'(uv_s3) <<< 1);
      w1_s4_r  <= W_W'(uu_s3) + (W_W'(uv_s3) <<< 1);
      uu_s4_r  <= uu_s3;
      uv_s4_r  <= uv_s3;
      dd_s4_r  <= dd_s3;
      d_s4_r   <= d_s3_r;
      v_s4_r   <= v_s3_r;
      dy_s4_r  <= dy_s3_r;
      a_s4_r   <= a_s3_r;
      y0_s4_r  <= y0_s3_r;
      y0p_s4_r <= y0p_s3_r;
      y1p_s4_r <= y1p_s3_r;
    end
  end

  // second product level
  che_mul #(.A_W(SQ_W), .B_W(D_W)) u_mul_c3 (.clk(clk), .en(en), .a(dd_s4_r), .b(d_s4_r), .p(c3_s6));
  che_mul #(.A_W(SQ_W), .B_W(D_W)) u_mul_g (.clk(clk), .en(en), .a(uu_s4_r), .b(dy_s4_r), .p(g_s6));
  che_mul #(.A_W(SQ_W), .B_W(D_W)) u_mul_m (.clk(clk), .en(en), .a(uv_s4_r), .b(dy_s4_r), .p(m_s6));
  che_mul #(.A_W(W_W), .B_W(DW)) u_mul_a0 (.clk(clk), .en(en), .a(w0_s4_r), .b(y0p_s4_r), .p(a0_s6));
  che_mul #(.A_W(W_W), .B_W(DW)) u_mul_a1 (.clk(clk), .en(en), .a(w1_s4_r), .b(y1p_s4_r), .p(a1_s6));
  che_mul #(.A_W(SQ_W), .B_W(DW)) u_mul_b0 (.clk(clk), .en(en), .a(uv_s4_r), .b(y0p_s4_r), .p(b0_s6));
  che_mul #(.A_W(SQ_W), .B_W(DW)) u_mul_b1 (.clk(clk), .en(en), .a(uu_s4_r), .b(y1p_s4_r), .p(b1_s6));

  always_ff @(posedge clk) begin
    if (en) begin
      d_s5_r  <= d_s4_r;
      v_s5_r  <= v_s4_r;
      a_s5_r  <= a_s4_r;
      y0_s5_r <= y0_s4_r;
      d_s6_r  <= d_s5_r;
      v_s6_r  <= v_s5_r;
      a_s6_r  <= a_s5_r;
      y0_s6_r <= y0_s5_r;
    end
  end

  // slope sums and 6 * dy * uv
  always_ff @(posedge clk) begin
    if (en) begin
      s_s7_r  <= S_W'(b0_s6) + S_W'(b1_s6);
      q_s7_r  <= Q_W'(a0_s6) + Q_W'(a1_s6);
      m6_s7_r <= (M6_W'(m_s6) <<< 2) + (M6_W'(m_s6) <<< 1);
      c3_s7_r <= c3_s6;
      g_s7_r  <= g_s6;
      d_s7_r  <= d_s6_r;
      v_s7_r  <= v_s6_r;
      a_s7_r  <= a_s6_r;
      y0_s7_r <= y0_s6_r;
    end
  end

  // third product level
  che_mul #(.A_W(C3_W), .B_W(DW)) u_mul_p1 (.clk(clk), .en(en), .a(c3_s7_r), .b(y0_s7_r), .p(p1_s9));
  che_mul #(.A_W(G_W), .B_W(A3_W)) u_mul_p2 (.clk(clk), .en(en), .a(g_s7_r), .b(a_s7_r), .p(p2_s9));
  che_mul #(.A_W(S_W), .B_W(D_W)) u_mul_t (.clk(clk), .en(en), .a(s_s7_r), .b(d_s7_r), .p(t_s9));
  che_mul #(.A_W(Q_W), .B_W(D_W)) u_mul_qd (.clk(clk), .en(en), .a(q_s7_r), .b(d_s7_r), .p(qd_s9));

  always_ff @(posedge clk) begin
    if (en) begin
      v_s8_r   <= v_s7_r;
      v_s9_r   <= v_s8_r;
      m6_s8_r  <= m6_s7_r;
      m6_s9_r  <= m6_s8_r;
      m6_s10_r <= m6_s9_r;
      m6_s11_r <= m6_s10_r;
      c3_s8_r  <= c3_s7_r;
      c3_s9_r  <= c3_s8_r;
      c3_s10_r <= c3_s9_r;
      c3_s11_r <= c3_s10_r;
      p1_s10_r <= p1_s9;
      p1_s11_r <= p1_s10_r;
      p2_s10_r <= p2_s9;
      p2_s11_r <= p2_s10_r;
      qd_s10_r <= qd_s9;
      qd_s11_r <= qd_s10_r;
    end
  end

  // fourth product level
  che_mul #(.A_W(T_W), .B_W(D_W)) u_mul_p3 (.clk(clk), .en(en), .a(t_s9), .b(v_s9_r), .p(p3_s11));

  // numerators and denominators
  always_ff @(posedge clk) begin
    if (en) begin
      nv_r   <= ((NW'(p1_s11_r) + NW'(p2_s11_r)) <<< FW) + NW'(p3_s11);
      nd_r   <= NW'(qd_s11_r) - (NW'(m6_s11_r) <<< FW);
      denv_r <= NW'(c3_s11_r) <<< FW;
      dend_r <= NW'(c3_s11_r);
    end
  end

  che_div u_div_value (
    .clk (clk),
    .en  (en),
    .num (nv_r),
    .den (denv_r),
    .res (res_v),
    .sat (sat_v)
  );

  che_div u_div_deriv (
    .clk (clk),
    .en  (en),
    .num (nd_r),
    .den (dend_r),
    .res (res_d),
    .sat (sat_d)
  );

  // output beat; equal end points force zero results
  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= zero_r[ZDEP-1] ? '0 : res_v;
      out_deriv_r <= zero_r[ZDEP-1] ? '0 : res_d;
      out_fault_r <= zero_r[ZDEP-1] | sat_v | sat_d;
    end
  end

  assign out_interp_value = out_value_r;
  assign out_interp_deriv = out_deriv_r;
  assign out_fault        = out_fault_r;

endmodule

// ===== sv/che_checker.sv =====
// Port-level checks for the cubic Hermite evaluator, bound to the top level.
// Depends on che_pkg and cubic_hermite_eval_defines.svh.
`timescale 1ns / 1ps
`include "cubic_hermite_eval_defines.svh"

module che_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [che_pkg::DATA_W-1:0]   out_interp_value,
  input logic [che_pkg::DATA_W-1:0]   out_interp_deriv,
  input logic                         out_fault
);

  // a held result beat stays offered
  `CHE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out beat dropped")

  // a held result beat keeps its data words
  `CHE_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_interp_value) && $stable(out_interp_deriv), "out payload changed")

  // a held result beat keeps its fault flag
  `CHE_ASSERT(a_fault_stable, out_valid && !out_ready |=> $stable(out_fault), "out fault changed")

  // input side is open exactly when the output register can move
  `CHE_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "in_ready mismatch")

  // reset empties the pipeline
  `CHE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "beat after reset")

endmodule

bind cubic_hermite_eval che_checker u_che_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_interp_value (out_interp_value),
  .out_interp_deriv (out_interp_deriv),
  .out_fault        (out_fault)
);
